FILE: rtl/bspr_pkg.sv
// shared types and constants of the button press scanner
`default_nettype none

package bspr_pkg;

   localparam int unsigned DataWidth  = 8;
   localparam int unsigned IndexWidth = 8;
   localparam int unsigned TdataWidth = 16;

   localparam logic [DataWidth-1:0] AllReleased = 8'b1111_1111;
   localparam logic [DataWidth-1:0] LongClear   = 8'b1111_1101;
   localparam logic [DataWidth-1:0] CountMax    = 8'b1111_1111;

   localparam logic [DataWidth-1:0] KeyMaskReset    = 8'b0110_1010;
   localparam logic [DataWidth-1:0] ShortTicksReset = 8'd5;
   localparam logic [DataWidth-1:0] LongUnitsReset  = 8'd20;
   localparam logic [DataWidth-1:0] MinRepeatReset  = 8'd2;

   typedef enum logic [IndexWidth-1:0] {
      REG_KEY_MASK    = 8'd0,
      REG_SHORT_TICKS = 8'd1,
      REG_LONG_UNITS  = 8'd2,
      REG_MIN_REPEAT  = 8'd3
   } reg_index_type;

   typedef struct packed {
      logic [DataWidth-1:0] key_mask;
      logic [DataWidth-1:0] short_ticks;
      logic [DataWidth-1:0] long_units;
      logic [DataWidth-1:0] min_repeat;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/bspr_csr.sv
// configuration register file of the button press scanner
`default_nettype none

module bspr_csr
   import bspr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [IndexWidth-1:0] wr_index,
   input  wire logic [DataWidth-1:0]  wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_KEY_MASK:    cfg_in.key_mask    = wr_data;
            REG_SHORT_TICKS: cfg_in.short_ticks = wr_data;
            REG_LONG_UNITS:  cfg_in.long_units  = wr_data;
            REG_MIN_REPEAT:  cfg_in.min_repeat  = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_mask    <= KeyMaskReset;
         cfg_ff.short_ticks <= ShortTicksReset;
         cfg_ff.long_units  <= LongUnitsReset;
         cfg_ff.min_repeat  <= MinRepeatReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/bspr_core.sv
// key state, press counters and event decision of the button press scanner
`default_nettype none

module bspr_core
   import bspr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [DataWidth-1:0] pins,
   input  wire logic                 speed_set,
   input  cfg_type                   cfg,
   output logic                      event_valid,
   output logic [DataWidth-1:0]      key_code
);

   logic [DataWidth-1:0] prev_code_ff, prev_code_in;
   logic [DataWidth-1:0] tick_count_ff, tick_count_in;
   logic [DataWidth-1:0] unit_count_ff, unit_count_in;
   logic                 long_active_ff, long_active_in;
   logic [DataWidth-1:0] repeat_limit_ff, repeat_limit_in;
   logic                 speed_on_ff, speed_on_in;

   logic [DataWidth-1:0] code;
   logic [DataWidth-1:0] tick_next;
   logic [DataWidth-1:0] unit_next;
   logic [DataWidth-1:0] half_limit;
   logic                 speed;

   always_comb begin
      code       = pins | cfg.key_mask;
      speed      = speed_on_ff | speed_set;
      tick_next  = (tick_count_ff < CountMax) ? tick_count_ff + 8'd1 : tick_count_ff;
      unit_next  = (unit_count_ff < CountMax) ? unit_count_ff + 8'd1 : unit_count_ff;
      half_limit = repeat_limit_ff >> 1;

      prev_code_in    = code;
      tick_count_in   = tick_count_ff;
      unit_count_in   = unit_count_ff;
      long_active_in  = long_active_ff;
      repeat_limit_in = repeat_limit_ff;
      speed_on_in     = speed;
      event_valid     = 1'b0;
      key_code        = '0;

      if (code == AllReleased || code != prev_code_ff) begin
         // release or key change
         speed_on_in = 1'b0;
         if ((tick_count_ff >= cfg.short_ticks || unit_count_ff != '0) && !long_active_ff) begin
            event_valid = 1'b1;
            key_code    = prev_code_ff;
         end
         if (unit_count_ff >= repeat_limit_ff) begin
            event_valid = 1'b1;
            key_code    = prev_code_ff & LongClear;
         end
         long_active_in  = 1'b0;
         repeat_limit_in = cfg.long_units;
         tick_count_in   = '0;
         unit_count_in   = '0;
      end else if (tick_next >= cfg.short_ticks) begin
         tick_count_in = '0;
         unit_count_in = unit_next;
         if (unit_next >= repeat_limit_ff) begin
            // long or repeat event
            event_valid    = 1'b1;
            key_code       = prev_code_ff & LongClear;
            unit_count_in  = '0;
            long_active_in = 1'b1;
            if (speed) begin
               repeat_limit_in = (half_limit <= cfg.min_repeat) ? cfg.min_repeat : half_limit;
            end
         end
      end else begin
         tick_count_in = tick_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_code_ff    <= '0;
         tick_count_ff   <= '0;
         unit_count_ff   <= '0;
         long_active_ff  <= 1'b0;
         repeat_limit_ff <= LongUnitsReset;
         speed_on_ff     <= 1'b0;
      end else if (step) begin
         prev_code_ff    <= prev_code_in;
         tick_count_ff   <= tick_count_in;
         unit_count_ff   <= unit_count_in;
         long_active_ff  <= long_active_in;
         repeat_limit_ff <= repeat_limit_in;
         speed_on_ff     <= speed_on_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/button_short_long_press_repeat_unit.sv
// top level of the button press scanner with short, long and repeat events
//
//  channel  direction  payload
//  req_     in         pins, speed_set (one scan tick per item)
//  rsp_     out        event_valid, key_code (one item per tick)
//  csr_     in         csr_index, csr_wdata (register write)
//
// an item enters the input register, passes the key logic and lands in the
// output register, one item per cycle sustained while the result is not
// stalled. synchronous reset clears the key state and loads register
// defaults. a stalled result holds the output register; the input register
// keeps taking one more item until both stages are full.
`default_nettype none

module button_short_long_press_repeat_unit
   import bspr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TdataWidth-1:0] req_tdata,   // pins[7:0], speed_set[8], zero pad
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [TdataWidth-1:0]      rsp_tdata,   // event_valid[0], key_code[8:1], zero pad
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [IndexWidth-1:0] csr_index,
   input  wire logic [DataWidth-1:0]  csr_wdata
);

   cfg_type cfg;

   logic                 in_vld_ff, in_vld_in;
   logic [DataWidth-1:0] pins_ff;
   logic                 speed_ff;
   logic                 out_vld_ff, out_vld_in;
   logic                 evt_ff;
   logic [DataWidth-1:0] key_ff;

   logic                 advance;
   logic                 evt;
   logic [DataWidth-1:0] key;

   assign csr_ready = 1'b1;

   bspr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   bspr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .pins        (pins_ff),
      .speed_set   (speed_ff),
      .cfg         (cfg),
      .event_valid (evt),
      .key_code    (key)
   );

   always_comb begin
      advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
      req_tready = !in_vld_ff || advance;
      in_vld_in  = req_tvalid || (in_vld_ff && !advance);
      out_vld_in = advance || (out_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= in_vld_in;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pins_ff  <= req_tdata[DataWidth-1:0];
         speed_ff <= req_tdata[DataWidth];
      end
      if (advance) begin
         evt_ff <= evt;
         key_ff <= key;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(TdataWidth-DataWidth-1){1'b0}}, key_ff, evt_ff};

endmodule

`default_nettype wire
